/* hdl/dto_pkg.sv */
// Shared constants for the dependency topological orderer.
`timescale 1ns / 1ps
package dto_pkg;
    // Default size of the task table.
    localparam int DEF_MAX_TASKS     = 16;
    // Default number of tracked resources.
    localparam int DEF_NUM_RESOURCES = 16;
    // Width of the resource masks carried by one task.
    localparam int MASK_W            = 16;
    // Width of the emitted task index.
    localparam int IDX_OUT_W         = 4;
endpackage

/* hdl/dto_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module dto_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hdl/dependency_topological_orderer.sv */
// Top level of the dependency topological orderer.
//   Channel  Direction  Ports
//   input    in         i_valid, o_ready, i_write_mask, i_read_mask, i_last
//   result   out        o_valid, i_ready, o_task_index, o_schedule_valid, o_last_result
// Task descriptors load at one per cycle. After the last descriptor the block builds one
// predecessor row per task (ST_BRD, then ST_BCALC), then runs the sort: each probe reads a
// task's predecessor row from RAM (ST_SRD) and checks it (ST_SCHK); a full pass restarts
// after each pick, so sorting N tasks takes up to about N*N probes. Each result then passes
// ST_ORD, ST_OLD and ST_OWAIT, which waits on i_ready. Input is not taken from the last
// descriptor until the final result transfer. Reset is synchronous and active low; no clearing pass.
`timescale 1ns / 1ps
module dependency_topological_orderer #(
    parameter int MAX_TASKS     = dto_pkg::DEF_MAX_TASKS,
    parameter int NUM_RESOURCES = dto_pkg::DEF_NUM_RESOURCES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dto_pkg::MASK_W-1:0]    i_write_mask,
    input  logic [dto_pkg::MASK_W-1:0]    i_read_mask,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dto_pkg::IDX_OUT_W-1:0] o_task_index,
    output logic                          o_schedule_valid,
    output logic                          o_last_result
);
    import dto_pkg::*;

    localparam int IDXW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNTW    = $clog2(MAX_TASKS + 1);
    localparam int RES_USED = (NUM_RESOURCES < MASK_W) ? NUM_RESOURCES : MASK_W;

    typedef enum logic [2:0] {
        ST_LOAD, ST_BRD, ST_BCALC, ST_SRD, ST_SCHK, ST_ORD, ST_OLD, ST_OWAIT
    } t_state;

    t_state                r_state;
    logic [CNTW-1:0]       r_count;
    logic [CNTW-1:0]       r_n;
    logic [IDXW-1:0]       r_j;
    logic [IDXW-1:0]       r_k;
    logic                  r_valid_flag;
    logic                  r_cyc;
    logic [MAX_TASKS-1:0]  r_emit;
    logic [IDXW-1:0]       r_own   [RES_USED];
    logic [RES_USED-1:0]   r_own_v;

    logic [IDXW-1:0]       n_own   [RES_USED];
    logic [RES_USED-1:0]   n_own_v;
    logic                  n_dup;

    logic                  in_xfer;
    logic                  room;
    logic [MASK_W-1:0]     mask_rdata;
    logic [MAX_TASKS-1:0]  pred_rdata;
    logic [MAX_TASKS-1:0]  pred_row;
    logic [IDXW-1:0]       order_rdata;
    logic                  pick;
    logic [IDXW+IDX_OUT_W-1:0] idx_ext;

    assign o_ready = (r_state == ST_LOAD);
    assign in_xfer = i_valid && o_ready;
    assign room    = (r_count < CNTW'(MAX_TASKS));

    // Read masks of the loaded tasks.
    dto_ram #(.WIDTH(MASK_W), .DEPTH(MAX_TASKS)) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (in_xfer && room),
        .i_waddr (r_count[IDXW-1:0]),
        .i_wdata (i_read_mask),
        .i_raddr (r_j),
        .o_rdata (mask_rdata)
    );

    // Predecessor row per task: bit w set means task w must come first.
    dto_ram #(.WIDTH(MAX_TASKS), .DEPTH(MAX_TASKS)) u_pred_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_BCALC),
        .i_waddr (r_j),
        .i_wdata (pred_row),
        .i_raddr (r_j),
        .o_rdata (pred_rdata)
    );

    // Emitted order.
    dto_ram #(.WIDTH(IDXW), .DEPTH(MAX_TASKS)) u_order_ram (
        .i_clk   (i_clk),
        .i_we    ((r_state == ST_SCHK) && pick),
        .i_waddr (r_n[IDXW-1:0]),
        .i_wdata (r_j),
        .i_raddr (r_k),
        .o_rdata (order_rdata)
    );

    // Resource ownership claims of the incoming task; later claimants are dropped.
    always_comb begin
        n_own   = r_own;
        n_own_v = r_own_v;
        n_dup   = 1'b0;
        for (int r = 0; r < RES_USED; r++) begin
            if (i_write_mask[r]) begin
                if (r_own_v[r]) begin
                    n_dup = 1'b1;
                end else begin
                    n_own[r]   = r_count[IDXW-1:0];
                    n_own_v[r] = 1'b1;
                end
            end
        end
    end

    // Predecessors of task j from its read mask, without self edges.
    always_comb begin
        pred_row = '0;
        for (int r = 0; r < RES_USED; r++) begin
            if (mask_rdata[r] && r_own_v[r] && (r_own[r] != r_j)) begin
                pred_row[r_own[r]] = 1'b1;
            end
        end
    end

    // Task j is ready when it is not emitted and all its predecessors are.
    assign pick = !r_emit[r_j] && ((pred_rdata & ~r_emit) == '0);

    assign idx_ext = r_cyc ? {{IDX_OUT_W{1'b0}}, r_k} : {{IDX_OUT_W{1'b0}}, order_rdata};

    // Sequencer and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_LOAD;
            r_count          <= '0;
            r_n              <= '0;
            r_j              <= '0;
            r_k              <= '0;
            r_valid_flag     <= 1'b1;
            r_cyc            <= 1'b0;
            r_emit           <= '0;
            r_own_v          <= '0;
            o_valid          <= 1'b0;
            o_task_index     <= '0;
            o_schedule_valid <= 1'b0;
            o_last_result    <= 1'b0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (in_xfer) begin
                        if (room) begin
                            r_own   <= n_own;
                            r_own_v <= n_own_v;
                            r_count <= r_count + 1'b1;
                            if (n_dup) begin
                                r_valid_flag <= 1'b0;
                            end
                        end else begin
                            r_valid_flag <= 1'b0;
                        end
                        if (i_last) begin
                            r_j     <= '0;
                            r_state <= ST_BRD;
                        end
                    end
                end
                ST_BRD: begin
                    r_state <= ST_BCALC;
                end
                ST_BCALC: begin
                    if (CNTW'(r_j) + 1'b1 == r_count) begin
                        r_j     <= '0;
                        r_n     <= '0;
                        r_state <= ST_SRD;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= ST_BRD;
                    end
                end
                ST_SRD: begin
                    r_state <= ST_SCHK;
                end
                ST_SCHK: begin
                    if (pick) begin
                        r_emit[r_j] <= 1'b1;
                        r_n         <= r_n + 1'b1;
                        r_j         <= '0;
                        if (r_n + 1'b1 == r_count) begin
                            r_k     <= '0;
                            r_state <= ST_ORD;
                        end else begin
                            r_state <= ST_SRD;
                        end
                    end else if (CNTW'(r_j) + 1'b1 == r_count) begin
                        // A full pass found nothing: a cycle remains.
                        r_cyc        <= 1'b1;
                        r_valid_flag <= 1'b0;
                        r_k          <= '0;
                        r_state      <= ST_ORD;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= ST_SRD;
                    end
                end
                ST_ORD: begin
                    r_state <= ST_OLD;
                end
                ST_OLD: begin
                    o_valid          <= 1'b1;
                    o_task_index     <= idx_ext[IDX_OUT_W-1:0];
                    o_schedule_valid <= r_valid_flag;
                    o_last_result    <= (CNTW'(r_k) + 1'b1 == r_count);
                    r_state          <= ST_OWAIT;
                end
                ST_OWAIT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        if (o_last_result) begin
                            // Set finished: return to the empty state.
                            r_count      <= '0;
                            r_valid_flag <= 1'b1;
                            r_cyc        <= 1'b0;
                            r_emit       <= '0;
                            r_own_v      <= '0;
                            r_j          <= '0;
                            r_state      <= ST_LOAD;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= ST_ORD;
                        end
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end
endmodule
